// ===== rtl/i85_pkg.sv =====
// shared types and constants for the 8085-subset execute block
`timescale 1ns / 1ps
package i85_pkg;

	localparam int ADDR_BITS_DEF = 16;
	localparam int NUM_REGS      = 7;
	localparam int WORD_BITS     = 8;

	// register codes
	localparam logic [2:0] REG_B = 3'd0;
	localparam logic [2:0] REG_C = 3'd1;
	localparam logic [2:0] REG_D = 3'd2;
	localparam logic [2:0] REG_E = 3'd3;
	localparam logic [2:0] REG_H = 3'd4;
	localparam logic [2:0] REG_L = 3'd5;
	localparam logic [2:0] REG_A = 3'd6;

	// instruction lengths
	localparam logic [2:0] LEN_ONE   = 3'd1;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;

	localparam logic [3:0] NIB_ZERO = 4'h0;
	localparam logic [3:0] NIB_FULL = 4'hF;

	typedef enum logic [4:0] {
		OP_SET  = 5'd0,
		OP_MVI  = 5'd1,
		OP_MOV  = 5'd2,
		OP_STA  = 5'd3,
		OP_LDA  = 5'd4,
		OP_ADD  = 5'd5,
		OP_SUB  = 5'd6,
		OP_ADI  = 5'd7,
		OP_INR  = 5'd8,
		OP_DCR  = 5'd9,
		OP_LHLD = 5'd10,
		OP_SHLD = 5'd11,
		OP_CMP  = 5'd12,
		OP_CMA  = 5'd13,
		OP_STAX = 5'd14,
		OP_XCHG = 5'd15,
		OP_JMP  = 5'd16,
		OP_JC   = 5'd17,
		OP_JNC  = 5'd18,
		OP_JZ   = 5'd19,
		OP_JNZ  = 5'd20
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EX1,
		ST_EX2
	} state_t;

endpackage

// ===== rtl/i85_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
module i85_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or read one entry a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== rtl/i8085_subset_execute.sv =====
// top level of the 8085-subset execute block
//
// Input channel (in_valid / in_stall) takes one pre-decoded instruction word:
// op, dst_reg, src_reg, imm and addr. Output channel (out_valid / out_stall)
// returns one result word per instruction: length, jump decision and target,
// accumulator and the four flags after the instruction.
// Registers and flags sit in flops; data memory is a single-port ram with a
// registered read. An accepted word is registered into EX1 (memory read
// issued in the accepting cycle), its result into the output register when
// it finishes; LHLD and SHLD also pass EX2 as they touch two bytes over the
// one port. Throughput is one word a cycle, with no output stall, for
// one-byte ops that write no memory; LHLD takes its next word as it leaves
// EX2, while SET/STA/STAX and SHLD go idle first. After reset the block
// sweeps all 2^ADDR_BITS bytes to zero, one byte a cycle, with in_stall high.
// When the receiver stalls, the result is held in the output register and
// execution of the next word waits; a word already read from memory is kept.
`timescale 1ns / 1ps
module i8085_subset_execute #(
	parameter int ADDR_BITS = i85_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  op,
	input  logic [2:0]  dst_reg,
	input  logic [2:0]  src_reg,
	input  logic [7:0]  imm,
	input  logic [15:0] addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  instr_length,
	output logic        jump_taken,
	output logic [15:0] jump_target,
	output logic [7:0]  accumulator,
	output logic        carry_flag,
	output logic        zero_flag,
	output logic        sign_flag,
	output logic        aux_carry_flag
);
	import i85_pkg::*;

	localparam int MEM_DEPTH = 1 << ADDR_BITS;

	state_t state_q, state_n;

	logic [ADDR_BITS-1:0] clr_q;
	logic [7:0]  regs_q [NUM_REGS];
	logic [7:0]  regs_n [NUM_REGS];
	logic        cy_q, z_q, s_q, ac_q;
	logic        cy_n, z_n, s_n, ac_n;

	op_t         op_s1;
	logic [2:0]  dst_s1, src_s1;
	logic [7:0]  imm_s1;
	logic [15:0] addr_s1;

	logic        rd_pending_q;
	logic [7:0]  rd_q;
	logic [7:0]  mem_val;

	logic                 mem_we;
	logic [ADDR_BITS-1:0] mem_addr;
	logic [7:0]           mem_wdata;
	logic [7:0]           mem_rdata;

	logic        out_free, fin, accept, accept_ok;
	logic        two_byte, store_op;
	logic [2:0]  len_n;
	logic        taken_n;
	logic [7:0]  rs, rdv;
	logic [8:0]  sum_w, diff_w;
	logic [7:0]  incdec;
	logic [15:0] pair;

	// data memory
	i85_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MEM_DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// handshake and sequencing conditions
	assign out_free  = !out_valid || !out_stall;
	assign two_byte  = (op_s1 == OP_LHLD) || (op_s1 == OP_SHLD);
	assign store_op  = (op_s1 == OP_SET) || (op_s1 == OP_STA) || (op_s1 == OP_STAX);
	assign fin       = ((state_q == ST_EX1) && !two_byte && out_free)
	                || ((state_q == ST_EX2) && out_free);
	assign accept_ok = (state_q == ST_IDLE)
	                || (fin && (state_q == ST_EX1) && !store_op)
	                || (fin && (state_q == ST_EX2) && (op_s1 == OP_LHLD));
	assign in_stall  = !accept_ok;
	assign accept    = in_valid && accept_ok;

	// read data held over stalls
	assign mem_val = rd_pending_q ? mem_rdata : rd_q;
	assign pair    = (src_s1 == REG_B) ? {regs_q[REG_B], regs_q[REG_C]}
	                                   : {regs_q[REG_D], regs_q[REG_E]};

	// memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = addr[ADDR_BITS-1:0];
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			ST_EX1: begin
				case (op_s1)
					OP_SET: begin
						mem_we    = 1'b1;
						mem_addr  = addr_s1[ADDR_BITS-1:0];
						mem_wdata = imm_s1;
					end
					OP_STA: begin
						mem_we    = 1'b1;
						mem_addr  = addr_s1[ADDR_BITS-1:0];
						mem_wdata = regs_q[REG_A];
					end
					OP_STAX: begin
						mem_we    = 1'b1;
						mem_addr  = pair[ADDR_BITS-1:0];
						mem_wdata = regs_q[REG_A];
					end
					OP_SHLD: begin
						mem_we    = 1'b1;
						mem_addr  = addr_s1[ADDR_BITS-1:0];
						mem_wdata = regs_q[REG_L];
					end
					OP_LHLD: begin
						mem_addr = addr_s1[ADDR_BITS-1:0] + 1'b1;
					end
					default: begin
						mem_addr = addr[ADDR_BITS-1:0];
					end
				endcase
			end
			ST_EX2: begin
				if (op_s1 == OP_SHLD) begin
					mem_we    = 1'b1;
					mem_addr  = addr_s1[ADDR_BITS-1:0] + 1'b1;
					mem_wdata = regs_q[REG_H];
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_CLEAR: if (&clr_q) state_n = ST_IDLE;
			ST_IDLE:  if (accept) state_n = ST_EX1;
			ST_EX1: begin
				if (two_byte) state_n = ST_EX2;
				else if (fin) state_n = accept ? ST_EX1 : ST_IDLE;
			end
			ST_EX2:   if (fin) state_n = accept ? ST_EX1 : ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	// execute
	always_comb begin
		regs_n  = regs_q;
		cy_n    = cy_q;
		z_n     = z_q;
		s_n     = s_q;
		ac_n    = ac_q;
		taken_n = 1'b0;
		len_n   = LEN_ONE;
		rs      = (src_s1 < 3'(NUM_REGS)) ? regs_q[src_s1] : '0;
		rdv     = (dst_s1 < 3'(NUM_REGS)) ? regs_q[dst_s1] : '0;
		sum_w   = {1'b0, regs_q[REG_A]} + {1'b0, rs};
		diff_w  = {1'b0, regs_q[REG_A]} - {1'b0, rs};
		incdec  = (op_s1 == OP_INR) ? rdv + 8'd1 : rdv - 8'd1;
		case (op_s1)
			OP_SET: len_n = LEN_FOUR;
			OP_MVI: begin
				if (dst_s1 < 3'(NUM_REGS)) regs_n[dst_s1] = imm_s1;
				len_n = LEN_TWO;
			end
			OP_MOV: if (dst_s1 < 3'(NUM_REGS)) regs_n[dst_s1] = rs;
			OP_STA: len_n = LEN_THREE;
			OP_LDA: begin
				regs_n[REG_A] = mem_val;
				len_n = LEN_THREE;
			end
			OP_ADD, OP_ADI: begin
				if (op_s1 == OP_ADI) begin
					sum_w = {1'b0, regs_q[REG_A]} + {1'b0, imm_s1};
					len_n = LEN_TWO;
				end
				regs_n[REG_A] = sum_w[7:0];
				cy_n = sum_w[8];
				z_n  = (sum_w[7:0] == 8'h00);
				s_n  = sum_w[7];
			end
			OP_SUB: begin
				regs_n[REG_A] = diff_w[7:0];
				cy_n = diff_w[8];
				z_n  = (diff_w[7:0] == 8'h00);
				s_n  = diff_w[7];
			end
			OP_CMP: begin
				cy_n = diff_w[8];
				z_n  = (diff_w[7:0] == 8'h00);
				s_n  = diff_w[7];
			end
			OP_INR, OP_DCR: begin
				if (dst_s1 < 3'(NUM_REGS)) regs_n[dst_s1] = incdec;
				z_n  = (incdec == 8'h00);
				s_n  = incdec[7];
				ac_n = (op_s1 == OP_INR) ? (incdec[3:0] == NIB_ZERO)
				                         : (incdec[3:0] == NIB_FULL);
			end
			OP_LHLD: begin
				regs_n[REG_H] = mem_val;
				len_n = LEN_THREE;
			end
			OP_SHLD: len_n = LEN_THREE;
			OP_CMA: regs_n[REG_A] = ~regs_q[REG_A];
			OP_XCHG: begin
				regs_n[REG_H] = regs_q[REG_D];
				regs_n[REG_D] = regs_q[REG_H];
				regs_n[REG_L] = regs_q[REG_E];
				regs_n[REG_E] = regs_q[REG_L];
			end
			OP_JMP: taken_n = 1'b1;
			OP_JC:  taken_n = cy_q;
			OP_JNC: taken_n = !cy_q;
			OP_JZ:  taken_n = z_q;
			OP_JNZ: taken_n = !z_q;
			default: len_n = LEN_ONE;
		endcase
		if (taken_n) len_n = LEN_THREE;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			rd_pending_q <= 1'b0;
			out_valid    <= 1'b0;
			cy_q         <= 1'b0;
			z_q          <= 1'b0;
			s_q          <= 1'b0;
			ac_q         <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
		end else begin
			state_q      <= state_n;
			rd_pending_q <= accept || ((state_q == ST_EX1) && (op_s1 == OP_LHLD));
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (fin) begin
				regs_q <= regs_n;
				cy_q   <= cy_n;
				z_q    <= z_n;
				s_q    <= s_n;
				ac_q   <= ac_n;
			end else if ((state_q == ST_EX1) && (op_s1 == OP_LHLD)) begin
				regs_q[REG_L] <= mem_val;
			end
			if (fin) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	// instruction and result words
	always_ff @(posedge clk) begin
		rd_q <= mem_val;
		if (accept) begin
			op_s1   <= op_t'(op);
			dst_s1  <= dst_reg;
			src_s1  <= src_reg;
			imm_s1  <= imm;
			addr_s1 <= addr;
		end
		if (fin) begin
			instr_length   <= len_n;
			jump_taken     <= taken_n;
			jump_target    <= taken_n ? addr_s1 : '0;
			accumulator    <= regs_n[REG_A];
			carry_flag     <= cy_n;
			zero_flag      <= z_n;
			sign_flag      <= s_n;
			aux_carry_flag <= ac_n;
		end
	end

	// checks
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (state_q != ST_CLEAR))
		else $error("word accepted during memory clear");

	a_accept_enters_ex1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_EX1))
		else $error("accepted word did not enter execute");

	a_ex2_two_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EX2) |-> ((op_s1 == OP_LHLD) || (op_s1 == OP_SHLD)))
		else $error("second memory cycle for a one-byte op");

	a_fin_sets_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> out_valid)
		else $error("finished word not presented");

endmodule
